FILE: rtl/indexed_queue_stack_buffer_defines.svh
// Assertion macros shared by the indexed queue/stack buffer checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef INDEXED_QUEUE_STACK_BUFFER_DEFINES_SVH
`define INDEXED_QUEUE_STACK_BUFFER_DEFINES_SVH

// Checked only while out of reset
`define IQSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included
`define IQSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/iqsb_pkg.sv
// Package for the indexed queue/stack buffer: operation and status codes,
// field widths and the default depth. No dependencies.
`timescale 1ns / 1ps

package iqsb_pkg;

  // Default number of stored words
  localparam int unsigned DEPTH_DEF = 64;

  // Field widths
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 7;
  localparam int unsigned TDATA_W = 48;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POP_BACK  = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

FILE: rtl/iqsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iqsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/indexed_queue_stack_buffer.sv
// Indexed queue/stack buffer: an ordered store of up to DEPTH signed 32-bit words
// held in one RAM with a single read and a single write port, driven by a small
// sequencer. Append and write at an index, and any item that ends in an error,
// go from acceptance straight to the done state; read at an index and pop from
// the back first pass through a wait state for the registered RAM read. Search
// and pop from the front walk the stored words one RAM read per cycle (search
// stops at the first match), then let the last read in flight land; the front
// pop also moves each word down one place through the write port. Only one item
// is in work at a time; a finished result sits in an output register so the next
// item can be accepted while it waits. No clearing pass after reset.
// Depends on iqsb_pkg and iqsb_ram.
`timescale 1ns / 1ps

module indexed_queue_stack_buffer #(
  parameter int unsigned DEPTH = iqsb_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] mode, [8:3] index, [40:9] value, [47:41] zero
  input  logic [iqsb_pkg::TDATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] data_out, [37:32] position, [38] found, [40:39] status,
  // [47:41] fill_count
  output logic [iqsb_pkg::TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > iqsb_pkg::INDEX_W) ? CW : iqsb_pkg::INDEX_W;
  localparam int unsigned YW = (CW > iqsb_pkg::FILL_W) ? CW : iqsb_pkg::FILL_W;
  localparam int unsigned PW = (AW > iqsb_pkg::POS_W) ? AW : iqsb_pkg::POS_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [iqsb_pkg::MODE_W-1:0]   mode_q, mode_d;
  logic [iqsb_pkg::WORD_W-1:0]   val_q, val_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 scan_q, scan_d;
  logic                          pend_q, pend_d;
  logic [AW-1:0]                 pidx_q, pidx_d;
  logic [iqsb_pkg::WORD_W-1:0]   data_q, data_d;
  logic [AW-1:0]                 pos_q, pos_d;
  logic                          found_q, found_d;
  logic [iqsb_pkg::STAT_W-1:0]   status_q, status_d;
  logic [iqsb_pkg::TDATA_W-1:0]  out_q, out_d;
  logic                          ovalid_q, ovalid_d;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [iqsb_pkg::WORD_W-1:0]   mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [iqsb_pkg::WORD_W-1:0]   mem_rdata;

  logic [iqsb_pkg::MODE_W-1:0]   in_mode;
  logic [iqsb_pkg::INDEX_W-1:0]  in_idx;
  logic [iqsb_pkg::WORD_W-1:0]   in_val;
  logic [XW-1:0]                 idx_x;
  logic [XW-1:0]                 cnt_x;
  logic                          idx_bad;
  logic                          is_full;
  logic                          is_empty;
  logic [CW-1:0]                 cnt_m1;
  logic                          word_eq;
  logic                          out_free;
  logic [YW-1:0]                 fill_x;
  logic [PW-1:0]                 pos_x;

  // Word store
  iqsb_ram #(
    .WIDTH (iqsb_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Input field unpacking and shared checks
  assign in_mode  = s_axis_tdata[2:0];
  assign in_idx   = s_axis_tdata[8:3];
  assign in_val   = s_axis_tdata[40:9];
  assign idx_x    = XW'(in_idx);
  assign cnt_x    = XW'(count_q);
  assign idx_bad  = idx_x >= cnt_x;
  assign is_full  = count_q == CW'(DEPTH);
  assign is_empty = count_q == '0;
  assign cnt_m1   = count_q - CW'(1);
  assign word_eq  = mem_rdata == val_q;
  assign out_free = !ovalid_q || m_axis_tready;
  assign fill_x   = YW'(count_q);
  assign pos_x    = PW'(pos_q);

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    val_d     = val_q;
    count_d   = count_q;
    scan_d    = scan_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    data_d    = data_q;
    pos_d     = pos_q;
    found_d   = found_q;
    status_d  = status_q;
    out_d     = out_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = val_q;
    mem_raddr = scan_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d   = in_mode;
          val_d    = in_val;
          data_d   = '0;
          pos_d    = '0;
          found_d  = 1'b0;
          status_d = iqsb_pkg::ST_OK;
          scan_d   = '0;
          pend_d   = 1'b0;
          state_d  = S_DONE;
          case (in_mode)
            iqsb_pkg::MODE_APPEND: begin
              if (is_full) begin
                status_d = iqsb_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AW-1:0];
                mem_wdata = in_val;
                count_d   = count_q + CW'(1);
              end
            end
            iqsb_pkg::MODE_READ: begin
              if (idx_bad) begin
                status_d = iqsb_pkg::ST_RANGE;
              end else begin
                mem_raddr = idx_x[AW-1:0];
                state_d   = S_WAIT;
              end
            end
            iqsb_pkg::MODE_WRITE: begin
              if (idx_bad) begin
                status_d = iqsb_pkg::ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_x[AW-1:0];
                mem_wdata = in_val;
              end
            end
            iqsb_pkg::MODE_SEARCH: begin
              state_d = S_SCAN;
            end
            iqsb_pkg::MODE_POP_FRONT: begin
              if (is_empty) begin
                status_d = iqsb_pkg::ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            iqsb_pkg::MODE_POP_BACK: begin
              if (is_empty) begin
                status_d = iqsb_pkg::ST_EMPTY;
              end else begin
                count_d   = cnt_m1;
                mem_raddr = cnt_m1[AW-1:0];
                state_d   = S_WAIT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // One stored word per cycle: read issued now, handled next cycle
      S_SCAN: begin
        if (mode_q == iqsb_pkg::MODE_SEARCH && pend_q && word_eq) begin
          found_d = 1'b1;
          pos_d   = pidx_q;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else begin
          // front pop: keep the head word, move the rest down one place
          if (mode_q == iqsb_pkg::MODE_POP_FRONT && pend_q) begin
            if (pidx_q == '0) begin
              data_d = mem_rdata;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pidx_q - AW'(1);
              mem_wdata = mem_rdata;
            end
          end
          if (scan_q != count_q) begin
            mem_raddr = scan_q[AW-1:0];
            pend_d    = 1'b1;
            pidx_d    = scan_q[AW-1:0];
            scan_d    = scan_q + CW'(1);
          end else begin
            pend_d = 1'b0;
            if (!pend_q) begin
              state_d = S_DONE;
              if (mode_q == iqsb_pkg::MODE_POP_FRONT) begin
                count_d = cnt_m1;
              end
            end
          end
        end
      end

      // Single read lands
      S_WAIT: begin
        data_d  = mem_rdata;
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_d    = {fill_x[iqsb_pkg::FILL_W-1:0], status_q, found_q,
                      pos_x[iqsb_pkg::POS_W-1:0], data_q};
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    val_q    <= val_d;
    scan_q   <= scan_d;
    pidx_q   <= pidx_d;
    data_q   <= data_d;
    pos_q    <= pos_d;
    found_q  <= found_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

endmodule

FILE: rtl/iqsb_checker.sv
// Port-level checker for the indexed queue/stack buffer, bound to the top level.
// Depends on iqsb_pkg and indexed_queue_stack_buffer_defines.svh.
`timescale 1ns / 1ps
`include "indexed_queue_stack_buffer_defines.svh"

module iqsb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [iqsb_pkg::TDATA_W-1:0] m_axis_tdata
);

  logic [iqsb_pkg::STAT_W-1:0] out_status;
  logic                        out_found;
  logic                        in_take;
  logic                        out_stall;
  logic                        out_no_data;

  assign out_status  = m_axis_tdata[40:39];
  assign out_found   = m_axis_tdata[38];
  assign in_take     = s_axis_tvalid && s_axis_tready;
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_no_data = m_axis_tdata[31:0] == '0 && m_axis_tdata[47:41] == '0;

  // One word in work at a time: input closes right after a word is taken
  `IQSB_ASSERT(a_busy_after_take, in_take |=> !s_axis_tready, "input ready after accept")

  // A stalled result word holds
  `IQSB_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed")

  // A search hit always reports ok
  `IQSB_ASSERT(a_hit_ok, m_axis_tvalid && out_found |-> out_status == iqsb_pkg::ST_OK, "hit error")

  // An empty pop leaves nothing stored and reads nothing
  `IQSB_ASSERT(a_empty_zero, m_axis_tvalid && out_status == iqsb_pkg::ST_EMPTY |-> out_no_data, "empty pop data")

  // No result word on the edge after one seen in reset
  `IQSB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

endmodule

bind indexed_queue_stack_buffer iqsb_checker u_iqsb_checker (.*);

FILE: dv/tb_indexed_queue_stack_buffer.sv
// Self-checking testbench for indexed_queue_stack_buffer: drives operation words
// with random gaps and stalls, and predicts every status word in a scoreboard class.
// Depends on iqsb_pkg and the RTL of indexed_queue_stack_buffer.
`timescale 1ns / 1ps

module tb_indexed_queue_stack_buffer;
  import iqsb_pkg::*;

  localparam int unsigned CLK_PERIOD   = 2;
  localparam int unsigned RANDOM_OPS   = 500;
  localparam int unsigned MAX_WAIT     = 16;
  // Slowest word: front pop of a full store plus both sides idling
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = DEPTH_DEF + 16;
  localparam int unsigned PAD_W        = TDATA_W - MODE_W - INDEX_W - WORD_W;

  // Modes with no operation behind them
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  // Result word layout, MSB first
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [STAT_W-1:0] status;
    logic              found;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] data;
  } status_word_t;

  // Shadow copy of the store; predicts one status word per accepted operation
  class store_tracker;
    logic [WORD_W-1:0] words [DEPTH_DEF];
    int unsigned       fill;
    status_word_t      pending [$];
    int unsigned       fails;
    int unsigned       ops_seen [8];
    int unsigned       status_seen [4];
    int unsigned       hits;
    int unsigned       peak_fill;

    function new();
      foreach (words[i]) words[i] = '0;
      foreach (ops_seen[i]) ops_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      fill      = 0;
      fails     = 0;
      hits      = 0;
      peak_fill = 0;
    endfunction

    function void apply_op(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                           logic [WORD_W-1:0] val);
      status_word_t r;
      r = '0;
      case (mode)
        MODE_APPEND: begin
          if (fill >= DEPTH_DEF) begin
            r.status = ST_FULL;
          end else begin
            words[fill] = val;
            fill++;
          end
        end
        MODE_READ: begin
          if (idx >= fill) r.status = ST_RANGE;
          else r.data = words[idx];
        end
        MODE_WRITE: begin
          if (idx >= fill) r.status = ST_RANGE;
          else words[idx] = val;
        end
        MODE_SEARCH: begin
          // first match wins
          for (int i = 0; i < fill && !r.found; i++) begin
            if (words[i] == val) begin
              r.found = 1'b1;
              r.pos   = POS_W'(i);
            end
          end
        end
        MODE_POP_FRONT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = words[0];
            for (int i = 1; i < fill; i++) words[i-1] = words[i];
            fill--;
          end
        end
        MODE_POP_BACK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            fill--;
            r.data = words[fill];
          end
        end
        default: ;
      endcase
      r.fill = FILL_W'(fill);
      ops_seen[mode]++;
      status_seen[r.status]++;
      if (r.found) hits++;
      if (fill > peak_fill) peak_fill = fill;
      pending.push_back(r);
    endfunction

    function void check_status_word(logic [TDATA_W-1:0] tdata);
      status_word_t got;
      status_word_t want;
      got = tdata;
      if (pending.size() == 0) begin
        $error("result word %h arrived with no prediction pending", tdata);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.data != want.data) begin
        $error("data_out: expected %h, actual %h", want.data, got.data);
        fails++;
      end
      if (got.pos != want.pos) begin
        $error("position: expected %0d, actual %0d", want.pos, got.pos);
        fails++;
      end
      if (got.found != want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        fails++;
      end
      if (got.status != want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fails++;
      end
      if (got.fill != want.fill) begin
        $error("fill_count: expected %0d, actual %0d", want.fill, got.fill);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;

  store_tracker tracker = new();
  bit           src_steady = 1'b0;

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  indexed_queue_stack_buffer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // [2:0] mode, [8:3] index, [40:9] value, [47:41] zero
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [31:0] data_out, [37:32] position, [38] found, [40:39] status, [47:41] fill_count
    .m_axis_tdata  (m_axis_tdata)
  );

  // Send one operation word after a random gap; predict it once accepted
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                         input logic [WORD_W-1:0] val);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, val, idx, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.apply_op(mode, idx, val);
  endtask

  // Result side: random stall before each word, with stretches of none
  initial begin : result_sink
    int unsigned stall;
    bit          steady;
    steady = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_status_word(m_axis_tdata);
  end

  // Ends the run when neither side moves a word for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  val;
    bit                 growing;
    int unsigned        pick;
    int unsigned        issued;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: errors on an empty store, spare modes, extremes, duplicates
    send_op(MODE_POP_FRONT, 6'd0,  32'd0);
    send_op(MODE_POP_BACK,  6'd0,  32'd0);
    send_op(MODE_READ,      6'd0,  32'd0);
    send_op(MODE_WRITE,     6'd63, 32'hFFFF_FFFF);
    send_op(MODE_SEARCH,    6'd0,  32'd0);
    send_op(MODE_SPARE_6,   6'd63, 32'hFFFF_FFFF);
    send_op(MODE_SPARE_7,   6'd21, 32'h5555_5555);
    send_op(MODE_APPEND,    6'd0,  32'h8000_0000);
    send_op(MODE_APPEND,    6'd63, 32'h7FFF_FFFF);
    send_op(MODE_APPEND,    6'd0,  32'd0);
    send_op(MODE_APPEND,    6'd0,  32'hFFFF_FFFF);
    send_op(MODE_APPEND,    6'd0,  32'h7FFF_FFFF);
    send_op(MODE_READ,      6'd4,  32'd0);
    send_op(MODE_READ,      6'd5,  32'd0);
    send_op(MODE_WRITE,     6'd0,  32'h0000_1234);
    send_op(MODE_READ,      6'd0,  32'd0);
    send_op(MODE_SEARCH,    6'd0,  32'h7FFF_FFFF);
    send_op(MODE_SEARCH,    6'd0,  32'h8000_0000);
    send_op(MODE_SEARCH,    6'd0,  32'hFFFF_FFFF);
    send_op(MODE_POP_FRONT, 6'd0,  32'd0);
    send_op(MODE_POP_BACK,  6'd0,  32'd0);
    send_op(MODE_READ,      6'd63, 32'd0);
    send_op(MODE_WRITE,     6'd2,  32'h8000_0000);
    send_op(MODE_SEARCH,    6'd0,  32'h8000_0000);

    // Random: alternate fill-up and drain phases so full and empty are both hit
    growing = 1'b1;
    issued  = 0;
    while (issued < RANDOM_OPS) begin
      if (tracker.fill == DEPTH_DEF && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (tracker.fill == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) == 0) growing = !growing;

      pick = $urandom_range(0, 99);
      if (pick < (growing ? 60 : 10))      mode = MODE_APPEND;
      else if (pick < (growing ? 68 : 18)) mode = MODE_READ;
      else if (pick < (growing ? 76 : 26)) mode = MODE_WRITE;
      else if (pick < (growing ? 88 : 38)) mode = MODE_SEARCH;
      else if (pick < (growing ? 92 : 68)) mode = MODE_POP_FRONT;
      else if (pick < 97)                  mode = MODE_POP_BACK;
      else mode = pick[0] ? MODE_SPARE_7 : MODE_SPARE_6;

      // mostly in range, sometimes anywhere
      if (tracker.fill > 0 && $urandom_range(0, 3) != 0) begin
        idx = INDEX_W'($urandom_range(0, tracker.fill - 1));
      end else begin
        idx = INDEX_W'($urandom_range(0, 63));
      end

      // searches mostly look for a stored word; small values make duplicates
      if (tracker.fill > 0 && (mode == MODE_SEARCH ? $urandom_range(0, 2) != 0
                                                  : $urandom_range(0, 7) == 0)) begin
        val = tracker.words[$urandom_range(0, tracker.fill - 1)];
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: val = 32'($urandom_range(0, 7)) - 32'd4;
          3:       val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          default: val = $urandom();
        endcase
      end

      send_op(mode, idx, val);
      if (mode != MODE_SPARE_6 && mode != MODE_SPARE_7) issued++;
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered: %0d append, %0d read, %0d write, %0d search (%0d hits),",
             tracker.ops_seen[MODE_APPEND], tracker.ops_seen[MODE_READ],
             tracker.ops_seen[MODE_WRITE], tracker.ops_seen[MODE_SEARCH], tracker.hits);
    $display("  %0d front pop, %0d back pop, %0d spare",
             tracker.ops_seen[MODE_POP_FRONT], tracker.ops_seen[MODE_POP_BACK],
             tracker.ops_seen[MODE_SPARE_6] + tracker.ops_seen[MODE_SPARE_7]);
    $display("Status seen: %0d ok, %0d out of range, %0d empty, %0d full; peak fill %0d",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_RANGE],
             tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_FULL], tracker.peak_fill);
    if (tracker.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/iqsb_pkg.sv
rtl/iqsb_ram.sv
rtl/indexed_queue_stack_buffer.sv
rtl/iqsb_checker.sv
dv/tb_indexed_queue_stack_buffer.sv
